>>> hdl/sbsrr_pkg.sv
// Package with the beat types, mode codes, status codes and constants of the reply receiver.
package sbsrr_pkg;

  typedef enum logic [1:0] {
    MODE_ARM  = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_HEADER   = 3'd2,
    ST_ID       = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_t;

  localparam logic [7:0]  HDR_BYTE      = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd4000;
  localparam logic [3:0]  ACK_LAST      = 4'd5;
  localparam logic [3:0]  WORD_LAST     = 4'd7;
  localparam logic [3:0]  POS_ID        = 4'd2;
  localparam logic [3:0]  POS_DATA_LO   = 4'd5;
  localparam logic [3:0]  POS_DATA_HI   = 4'd6;

  typedef struct packed {
    logic [1:0] mode;
    logic       want_data;
    logic [7:0] reply_id;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] read_word;
  } out_beat_t;

endpackage

>>> hdl/servo_bus_status_reply_receiver_unit.sv
// Servo bus status reply receiver: collects reply bytes and reports one status per reply.
//
// The input channel carries one beat per bus event: an arm beat that starts a
// reply with its expected ID and length, a received byte, or a one microsecond
// tick. The output channel carries one beat per finished reply, with the status
// and the little-endian data word of a good word reply.
// Each input beat is handled in the cycle it is accepted, and the state is
// updated at that edge. A result is registered and shows on the output in the
// cycle after the beat that finished the reply, that is the last byte or the tick
// that ran past the timeout. One beat can be taken every cycle unless stalled.
// The output register holds its beat until it is taken. While it is full and
// the receiver does not take it, the input is stalled; it resumes in the same
// cycle the output beat is taken.
// Reset drops any reply in progress, empties the output register and sets the
// timeout register to 4000 ticks. The timeout register may be written through
// the configuration port whenever the block is idle.
module servo_bus_status_reply_receiver_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sbsrr_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbsrr_pkg::out_beat_t out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import sbsrr_pkg::*;

  logic [15:0] timeout_r;
  logic        armed_r, armed_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic        expect_word_r, expect_word_nxt;
  logic [7:0]  expected_id_r, expected_id_nxt;
  logic [7:0]  sum_acc_r, sum_acc_nxt;
  logic        header_bad_r, header_bad_nxt;
  logic        id_bad_r, id_bad_nxt;
  logic [15:0] word_acc_r, word_acc_nxt;
  logic [15:0] idle_count_r, idle_count_nxt;
  logic        out_valid_r;
  out_beat_t   out_data_r, result;
  logic        emit;
  logic        accept;
  logic [3:0]  last_pos;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign last_pos  = expect_word_r ? WORD_LAST : ACK_LAST;

  always_comb begin
    armed_nxt       = armed_r;
    byte_count_nxt  = byte_count_r;
    expect_word_nxt = expect_word_r;
    expected_id_nxt = expected_id_r;
    sum_acc_nxt     = sum_acc_r;
    header_bad_nxt  = header_bad_r;
    id_bad_nxt      = id_bad_r;
    word_acc_nxt    = word_acc_r;
    idle_count_nxt  = idle_count_r;
    emit            = 1'b0;
    result.status    = ST_OK;
    result.read_word = 16'd0;
    case (in_data.mode)
      MODE_ARM: begin
        armed_nxt       = 1'b1;
        byte_count_nxt  = 4'd0;
        expect_word_nxt = in_data.want_data;
        expected_id_nxt = in_data.reply_id;
        sum_acc_nxt     = 8'd0;
        header_bad_nxt  = 1'b0;
        id_bad_nxt      = 1'b0;
        word_acc_nxt    = 16'd0;
        idle_count_nxt  = 16'd0;
      end
      MODE_TICK: begin
        if (armed_r) begin
          if (idle_count_r >= timeout_r) begin
            emit          = 1'b1;
            result.status = ST_TIMEOUT;
          end else begin
            idle_count_nxt = idle_count_r + 16'd1;
          end
        end
      end
      MODE_BYTE: begin
        if (armed_r) begin
          idle_count_nxt = 16'd0;
          if (byte_count_r < 4'd2) begin
            if (in_data.rx_byte != HDR_BYTE) header_bad_nxt = 1'b1;
            byte_count_nxt = byte_count_r + 4'd1;
          end else if (byte_count_r < last_pos) begin
            if (byte_count_r == POS_ID && in_data.rx_byte != expected_id_r) id_bad_nxt = 1'b1;
            sum_acc_nxt = sum_acc_r + in_data.rx_byte;
            if (byte_count_r == POS_DATA_LO) begin
              word_acc_nxt = {word_acc_r[15:8], in_data.rx_byte};
            end else if (byte_count_r == POS_DATA_HI) begin
              word_acc_nxt = {in_data.rx_byte, word_acc_r[7:0]};
            end
            byte_count_nxt = byte_count_r + 4'd1;
          end else begin
            emit = 1'b1;
            if (header_bad_r) begin
              result.status = ST_HEADER;
            end else if (id_bad_r) begin
              result.status = ST_ID;
            end else if (~sum_acc_r != in_data.rx_byte) begin
              result.status = ST_CHECKSUM;
            end else begin
              result.status    = ST_OK;
              result.read_word = expect_word_r ? word_acc_r : 16'd0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (emit) armed_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RESET;
      armed_r       <= 1'b0;
      byte_count_r  <= 4'd0;
      expect_word_r <= 1'b0;
      expected_id_r <= 8'd0;
      sum_acc_r     <= 8'd0;
      header_bad_r  <= 1'b0;
      id_bad_r      <= 1'b0;
      word_acc_r    <= 16'd0;
      idle_count_r  <= 16'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      if (accept) begin
        armed_r       <= armed_nxt;
        byte_count_r  <= byte_count_nxt;
        expect_word_r <= expect_word_nxt;
        expected_id_r <= expected_id_nxt;
        sum_acc_r     <= sum_acc_nxt;
        header_bad_r  <= header_bad_nxt;
        id_bad_r      <= id_bad_nxt;
        word_acc_r    <= word_acc_nxt;
        idle_count_r  <= idle_count_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) out_data_r <= result;
  end

  // A finished reply always leaves the receiver disarmed.
  a_disarm_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit |=> !armed_r)
    else $error("receiver still armed after a result");

  // An armed reply never runs past the last byte of a word reply.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> byte_count_r <= WORD_LAST)
    else $error("byte count past reply length");

  // Only a good reply carries a data word.
  a_word_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.read_word == 16'd0)
    else $error("data word on a failed reply");

  // A new result is only produced when the output register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit |-> !out_valid_r || out_ready)
    else $error("result overwrote a pending beat");

endmodule

>>> tb/sv/servo_bus_status_reply_receiver_unit_test.sv
// Self-checking testbench for the servo bus status reply receiver unit.
`timescale 1ns / 1ps

module servo_bus_status_reply_receiver_unit_test;
  import sbsrr_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic [7:0] ACK_LEN_FIELD  = 8'd2;
  localparam logic [7:0] WORD_LEN_FIELD = 8'd4;
  localparam int         DRAIN_CYCLES   = 4;
  localparam int         CYCLE_LIMIT    = 1000000;
  localparam int         STALL_CYCLES   = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_we;
  logic [15:0] cfg_wdata;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;
  int items_sent;
  int mismatch_count;
  int cycle_count;

  logic [15:0] timeout_limit;
  logic        rx_armed;
  logic [3:0]  rx_pos;
  logic        rx_want_word;
  logic [7:0]  rx_expected_id;
  logic [7:0]  rx_sum;
  logic        rx_hdr_bad;
  logic        rx_id_bad;
  logic [15:0] rx_word;
  logic [15:0] rx_idle;
  out_beat_t   expected_replies[$];

  servo_bus_status_reply_receiver_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_reply_state();
    rx_armed       = 1'b0;
    rx_pos         = '0;
    rx_want_word   = 1'b0;
    rx_expected_id = '0;
    rx_sum         = '0;
    rx_hdr_bad     = 1'b0;
    rx_id_bad      = 1'b0;
    rx_word        = '0;
    rx_idle        = '0;
  endfunction

  function automatic void predict_reply_beat(input in_beat_t b);
    logic [3:0] last_pos;
    out_beat_t  r;
    last_pos = rx_want_word ? WORD_LAST : ACK_LAST;
    r = '0;
    case (b.mode)
      MODE_ARM: begin
        clear_reply_state();
        rx_armed       = 1'b1;
        rx_want_word   = b.want_data;
        rx_expected_id = b.reply_id;
      end
      MODE_TICK: if (rx_armed) begin
        if (rx_idle >= timeout_limit) begin
          r.status = ST_TIMEOUT;
          expected_replies.push_back(r);
          rx_armed = 1'b0;
        end else begin
          rx_idle = rx_idle + 16'd1;
        end
      end
      MODE_BYTE: if (rx_armed) begin
        rx_idle = '0;
        if (rx_pos < POS_ID) begin
          if (b.rx_byte != HDR_BYTE) rx_hdr_bad = 1'b1;
          rx_pos = rx_pos + 4'd1;
        end else if (rx_pos < last_pos) begin
          if (rx_pos == POS_ID && b.rx_byte != rx_expected_id) rx_id_bad = 1'b1;
          rx_sum = rx_sum + b.rx_byte;
          if (rx_pos == POS_DATA_LO) rx_word[7:0] = b.rx_byte;
          else if (rx_pos == POS_DATA_HI) rx_word[15:8] = b.rx_byte;
          rx_pos = rx_pos + 4'd1;
        end else begin
          if (rx_hdr_bad) r.status = ST_HEADER;
          else if (rx_id_bad) r.status = ST_ID;
          else if (~rx_sum != b.rx_byte) r.status = ST_CHECKSUM;
          else begin
            r.status = ST_OK;
            if (rx_want_word) r.read_word = rx_word;
          end
          expected_replies.push_back(r);
          rx_armed = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int expected);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, expected);
  endtask

  always @(posedge clk) begin : reply_monitor
    out_beat_t oldest;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply status", int'(out_data.status), -1);
        end else begin
          oldest = expected_replies.pop_front();
          if (out_data.status != oldest.status)
            report_mismatch("status", int'(out_data.status), int'(oldest.status));
          if (out_data.read_word != oldest.read_word)
            report_mismatch("read_word", int'(out_data.read_word), int'(oldest.read_word));
        end
      end
      if (cfg_we) timeout_limit = cfg_wdata;
      if (in_valid && in_ready) predict_reply_beat(in_data);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[servo_bus_status_reply_receiver_unit] ERROR");
      $finish;
    end
  end

  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_beat_t beat_of(input logic [1:0] m, input logic w,
                                       input logic [7:0] id, input logic [7:0] b);
    in_beat_t r;
    r.mode      = m;
    r.want_data = w;
    r.reply_id  = id;
    r.rx_byte   = b;
    return r;
  endfunction

  function automatic in_beat_t tick_beat();
    return beat_of(MODE_TICK, 1'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= beat_of(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    drain_replies();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(7))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(6));
    endcase
  endfunction

  // Arms a reply and sends its frame, with optional flaws, an early cut and idle ticks.
  task automatic send_reply(input logic want, input logic [7:0] id, input logic [15:0] word,
                            input logic bad_hdr, input logic bad_id, input logic bad_chk,
                            input int cut_at, input int tick_max);
    logic [7:0] frame[$];
    logic [7:0] sum;
    send_beat(beat_of(MODE_ARM, want, id, 8'($urandom)));
    frame.push_back(HDR_BYTE);
    frame.push_back(HDR_BYTE);
    frame.push_back(bad_id ? id ^ 8'($urandom_range(255, 1)) : id);
    frame.push_back(want ? WORD_LEN_FIELD : ACK_LEN_FIELD);
    frame.push_back(8'($urandom));
    if (want) begin
      frame.push_back(word[7:0]);
      frame.push_back(word[15:8]);
    end
    sum = '0;
    for (int i = 2; i < frame.size(); i++) sum = sum + frame[i];
    frame.push_back(bad_chk ? ~sum ^ 8'($urandom_range(255, 1)) : ~sum);
    if (bad_hdr) frame[$urandom_range(1)] = 8'($urandom_range(254));
    for (int i = 0; i < frame.size() && i != cut_at; i++) begin
      if ($urandom_range(5) == 0) repeat ($urandom_range(tick_max)) send_beat(tick_beat());
      send_beat(beat_of(MODE_BYTE, 1'($urandom), 8'($urandom), frame[i]));
    end
  endtask

  task automatic test_ignored_beats();
    send_beat(beat_of(MODE_BYTE, 1'b1, 8'hFF, 8'hFF));
    send_beat(beat_of(MODE_TICK, 1'b0, 8'h00, 8'h00));
    send_beat(beat_of(MODE_UNUSED, 1'b1, 8'hFF, 8'hFF));
  endtask

  task automatic test_reply_extremes();
    send_reply(1'b1, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, -1, 0);
    send_reply(1'b0, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b1, -1, 0);
  endtask

  task automatic test_rearm_mid_reply();
    send_reply(1'b1, 8'($urandom), 16'($urandom), 1'b0, 1'b0, 1'b0, 2, 0);
    send_reply(1'b0, 8'($urandom), 16'($urandom), 1'b0, 1'b0, 1'b1, -1, 0);
  endtask

  task automatic test_timeout_register();
    write_timeout(16'h0000);
    send_beat(beat_of(MODE_ARM, 1'b1, 8'($urandom), 8'($urandom)));
    send_beat(tick_beat());
    send_beat(beat_of(MODE_ARM, 1'b0, 8'($urandom), 8'($urandom)));
    send_beat(beat_of(MODE_BYTE, 1'b0, 8'($urandom), HDR_BYTE));
    send_beat(tick_beat());
    write_timeout(16'd3);
    send_beat(beat_of(MODE_ARM, 1'b0, 8'($urandom), 8'($urandom)));
    repeat (2) send_beat(tick_beat());
    write_timeout(16'd1);
    send_beat(tick_beat());
  endtask

  task automatic test_output_backpressure();
    stall_request = STALL_CYCLES;
    repeat (3) send_reply(1'b1, 8'($urandom), 16'($urandom), 1'b0, 1'b0, 1'b0, -1, 0);
    drain_replies();
  endtask

  task automatic test_random_replies(input int beat_goal);
    int start_count;
    int ignored;
    int tick_max;
    start_count = items_sent;
    ignored = 0;
    write_timeout(pick_timeout());
    while (items_sent - start_count - ignored < beat_goal) begin
      tick_max = (timeout_limit < 16'd8) ? int'(timeout_limit) + 1 : 3;
      case ($urandom_range(19))
        0: write_timeout(pick_timeout());
        1, 2: begin
          send_beat(beat_of(2'($urandom_range(MODE_UNUSED, MODE_BYTE)), 1'($urandom),
                            8'($urandom), 8'($urandom)));
          ignored++;
        end
        default: send_reply(1'($urandom), 8'($urandom), 16'($urandom),
                            $urandom_range(7) == 0, $urandom_range(7) == 0,
                            $urandom_range(7) == 0,
                            ($urandom_range(9) == 0) ? int'($urandom_range(7)) : -1,
                            tick_max);
      endcase
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    send_idle_pct  = 35;
    recv_idle_pct  = 59;
    stall_request  = 0;
    items_sent     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    timeout_limit  = TIMEOUT_RESET;
    clear_reply_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_ignored_beats();
    test_reply_extremes();
    test_rearm_mid_reply();
    test_timeout_register();
    test_random_replies(350);

    send_idle_pct = 59;
    recv_idle_pct = 35;
    test_output_backpressure();
    test_random_replies(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_replies(350);

    drain_replies();
    if (mismatch_count == 0)
      $display("[servo_bus_status_reply_receiver_unit] OK");
    else
      $display("[servo_bus_status_reply_receiver_unit] ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/sbsrr_pkg.sv
hdl/servo_bus_status_reply_receiver_unit.sv
tb/sv/servo_bus_status_reply_receiver_unit_test.sv
